[sv/wtps_pkg.sv]
// ----------------------------------------------------------------------------
// wtps_pkg
// Shared types and constants of the weighted triangle point sampler.
// ----------------------------------------------------------------------------
package wtps_pkg;

	localparam int MAX_CELLS_DEF  = 256;
	localparam int MAX_POINTS_DEF = 256;

	localparam int IDX_W   = 8;
	localparam int COORD_W = 16;
	localparam int FRAC_W  = 16;
	localparam int TOTAL_W = 24;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [1:0] {
		FN_WRITE_POINT = 2'd0,
		FN_APPEND      = 2'd1,
		FN_SAMPLE      = 2'd2,
		FN_CLEAR       = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_CELL = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		func_t                func;
		logic [IDX_W-1:0]     point_index;
		logic [COORD_W-1:0]   coord_x;
		logic [COORD_W-1:0]   coord_y;
		logic [IDX_W-1:0]     node_a;
		logic [IDX_W-1:0]     node_b;
		logic [IDX_W-1:0]     node_c;
		logic [FRAC_W-1:0]    weight;
		logic [FRAC_W-1:0]    pick_random;
		logic [FRAC_W-1:0]    radial_random;
		logic [FRAC_W-1:0]    split_random;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] sample_x;
		logic [COORD_W-1:0] sample_y;
		logic [IDX_W-1:0]   cell_index;
		status_t            status;
	} res_t;

endpackage

[sv/wtps_mult.sv]
// ----------------------------------------------------------------------------
// wtps_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wtps_mult (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [wtps_pkg::MUL_A_W-1:0] op_a,
	input  logic signed [wtps_pkg::MUL_B_W-1:0] op_b,
	output logic signed [wtps_pkg::MUL_P_W-1:0] prod_q
);
	import wtps_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

[sv/wtps_core.sv]
// ----------------------------------------------------------------------------
// wtps_core
// Sequencer with point and cell memories: cell search, square root and
// interpolation through the shared multiplier.
// ----------------------------------------------------------------------------
module wtps_core #(
	parameter int MAX_CELLS  = wtps_pkg::MAX_CELLS_DEF,
	parameter int MAX_POINTS = wtps_pkg::MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  wtps_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output wtps_pkg::res_t   res
);
	import wtps_pkg::*;

	localparam int CW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNTW = $clog2(MAX_CELLS + 1);
	localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int ACC_W = 20;
	localparam int CELL_W = TOTAL_W + 3 * IDX_W;

	typedef enum logic [4:0] {
		S_IDLE, S_TGT, S_SRD, S_SCMP, S_VERT, S_PA, S_PB, S_PC, S_SQRT,
		S_MSR, S_MX1, S_MX2, S_MY1, S_MY2, S_FIN, S_DONE
	} state_t;

	function automatic logic [PW-1:0] idx_mod(input logic [IDX_W-1:0] v);
		logic [19:0] r;
		r = 20'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (20'(MAX_POINTS) << k)) begin
				r = r - (20'(MAX_POINTS) << k);
			end
		end
		return PW'(r);
	endfunction

	function automatic logic [COORD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > ACC_W'(32767)) begin
			return 16'h7fff;
		end else if (v < -ACC_W'(32768)) begin
			return 16'h8000;
		end
		return v[COORD_W-1:0];
	endfunction

	logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
	logic [CELL_W-1:0]    cell_mem [MAX_CELLS];
	logic [2*COORD_W-1:0] pt_rd_q;
	logic [CELL_W-1:0]    cell_rd_q;
	logic                 pt_we;
	logic                 cell_we;
	logic [PW-1:0]        pt_raddr;
	logic [CW-1:0]        cell_raddr;

	state_t               state_q;
	cmd_t                 cmd_q;
	res_t                 res_q;
	logic [CNTW-1:0]      count_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CNTW-1:0]      lo_q;
	logic [CNTW-1:0]      hi_q;
	logic [CNTW:0]        mid_sum;
	logic [CNTW-1:0]      mid;
	logic [IDX_W-1:0]     ib_q;
	logic [IDX_W-1:0]     ic_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [31:0]          rad_q;
	logic [19:0]          rem_q;
	logic [FRAC_W-1:0]    root_q;
	logic [3:0]           step_q;
	logic [FRAC_W-1:0]    sr_q;
	logic signed [ACC_W-1:0] accx_q, accy_q;
	logic [TOTAL_W:0]     sum_w;
	logic [TOTAL_W-1:0]   new_total;
	logic [19:0]          rem_sh;
	logic [19:0]          trial;
	logic                 table_full;
	logic                 sample_empty;
	status_t              idle_status;
	logic                 mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   prod_sh;
	logic signed [MUL_B_W-1:0] dx_ba, dy_ba, dx_cb, dy_cb;

	wtps_mult u_mult (
		.clk   (clk),
		.en    (mul_en),
		.op_a  (mul_a),
		.op_b  (mul_b),
		.prod_q(prod_q)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CNTW:1];
	assign sum_w     = {1'b0, total_q} + (TOTAL_W+1)'(cmd.weight);
	assign new_total = sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
	assign rem_sh    = {rem_q[17:0], rad_q[31:30]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign prod_sh   = ACC_W'(prod_q >>> FRAC_W);
	assign dx_ba     = MUL_B_W'(bx_q) - MUL_B_W'(ax_q);
	assign dy_ba     = MUL_B_W'(by_q) - MUL_B_W'(ay_q);
	assign dx_cb     = MUL_B_W'(cx_q) - MUL_B_W'(bx_q);
	assign dy_cb     = MUL_B_W'(cy_q) - MUL_B_W'(by_q);
	assign table_full   = !(count_q < CNTW'(MAX_CELLS));
	assign sample_empty = (count_q == '0) || (total_q == '0);
	assign pt_we     = cmd_valid && cmd_ready && (cmd.func == FN_WRITE_POINT);
	assign cell_we   = cmd_valid && cmd_ready && (cmd.func == FN_APPEND)
		&& !table_full;

	always_comb begin
		priority if (cmd.func == FN_APPEND && table_full) begin
			idle_status = ST_FULL;
		end else if (cmd.func == FN_SAMPLE && sample_empty) begin
			idle_status = ST_NO_CELL;
		end else begin
			idle_status = ST_OK;
		end
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_TGT: begin
				mul_a = MUL_A_W'(total_q);
				mul_b = MUL_B_W'(cmd_q.pick_random);
			end
			S_MSR: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = MUL_B_W'(cmd_q.split_random);
			end
			S_MX1: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = dx_ba;
			end
			S_MX2: begin
				mul_a = MUL_A_W'(sr_q);
				mul_b = dx_cb;
			end
			S_MY1: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = dy_ba;
			end
			S_MY2: begin
				mul_a = MUL_A_W'(sr_q);
				mul_b = dy_cb;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_VERT:  pt_raddr = idx_mod(cell_rd_q[TOTAL_W +: IDX_W]);
			S_PA:    pt_raddr = idx_mod(ib_q);
			default: pt_raddr = idx_mod(ic_q);
		endcase
		cell_raddr = (lo_q < hi_q) ? CW'(mid) : CW'(lo_q);
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[idx_mod(cmd.point_index)] <= {cmd.coord_y, cmd.coord_x};
		end
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[CW'(count_q)] <= {cmd.node_c, cmd.node_b, cmd.node_a, new_total};
		end
		cell_rd_q <= cell_mem[cell_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						res_q <= '{sample_x: '0, sample_y: '0, cell_index: '0,
							status: idle_status};
						lo_q  <= '0;
						hi_q  <= count_q;
						if (cmd.func == FN_SAMPLE && !sample_empty) begin
							state_q <= S_TGT;
						end else begin
							state_q <= S_DONE;
						end
						unique case (cmd.func)
							FN_APPEND: begin
								if (!table_full) begin
									total_q <= new_total;
									count_q <= count_q + 1'b1;
								end
							end
							FN_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_TGT: begin
					state_q <= S_SRD;
				end
				S_SRD: begin
					if (lo_q < hi_q) begin
						state_q <= S_SCMP;
					end else if (lo_q < count_q) begin
						state_q <= S_VERT;
					end else begin
						res_q.status <= ST_NO_CELL;
						state_q <= S_DONE;
					end
				end
				S_SCMP: begin
					if ({cell_rd_q[TOTAL_W-1:0], 16'h0000} > prod_q[TOTAL_W+FRAC_W-1:0]) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + 1'b1;
					end
					state_q <= S_SRD;
				end
				S_VERT: begin
					ib_q <= cell_rd_q[TOTAL_W+IDX_W +: IDX_W];
					ic_q <= cell_rd_q[TOTAL_W+2*IDX_W +: IDX_W];
					state_q <= S_PA;
				end
				S_PA: begin
					ax_q <= pt_rd_q[COORD_W-1:0];
					ay_q <= pt_rd_q[2*COORD_W-1:COORD_W];
					state_q <= S_PB;
				end
				S_PB: begin
					bx_q <= pt_rd_q[COORD_W-1:0];
					by_q <= pt_rd_q[2*COORD_W-1:COORD_W];
					state_q <= S_PC;
				end
				S_PC: begin
					cx_q <= pt_rd_q[COORD_W-1:0];
					cy_q <= pt_rd_q[2*COORD_W-1:COORD_W];
					rad_q  <= {cmd_q.radial_random, 16'h0000};
					rem_q  <= '0;
					root_q <= '0;
					step_q <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					rad_q <= {rad_q[29:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[FRAC_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[FRAC_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 4'hf) begin
						state_q <= S_MSR;
					end
				end
				S_MSR: begin
					state_q <= S_MX1;
				end
				S_MX1: begin
					sr_q <= prod_q[2*FRAC_W-1:FRAC_W];
					state_q <= S_MX2;
				end
				S_MX2: begin
					accx_q <= ACC_W'(ax_q) + prod_sh;
					state_q <= S_MY1;
				end
				S_MY1: begin
					accx_q <= accx_q + prod_sh;
					state_q <= S_MY2;
				end
				S_MY2: begin
					accy_q <= ACC_W'(ay_q) + prod_sh;
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q <= '{sample_x: sat16(accx_q), sample_y: sat16(accy_q + prod_sh),
						cell_index: IDX_W'(lo_q), status: ST_OK};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRD || state_q == S_SCMP) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("Search bounds out of order.");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_CELLS))
		else $error("Cell count exceeds the table size.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_OK) |->
		(res.sample_x == '0 && res.sample_y == '0 && res.cell_index == '0))
		else $error("Failed item carries nonzero fields.");

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MSR) |-> $past(state_q == S_SQRT))
		else $error("Root finished early.");

endmodule

[sv/weighted_triangle_point_sampler_unit.sv]
// ----------------------------------------------------------------------------
// weighted_triangle_point_sampler_unit
// Weighted triangle choice by cumulative weight and uniform point sampling.
// ----------------------------------------------------------------------------
// Write point, append cell and clear items go from idle straight to done. A draw
// item runs a binary search over the cumulative weights, with each probe on the
// cell memory read port, three point memory reads, a bit-pair square root and six
// products through one shared multiplier. One item is worked at a time; a finished
// result waits in the output register while the next item is taken.
module weighted_triangle_point_sampler_unit #(
	parameter int MAX_CELLS  = wtps_pkg::MAX_CELLS_DEF,
	parameter int MAX_POINTS = wtps_pkg::MAX_POINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_index, coord_x, coord_y, node_a, node_b, node_c, weight,
	// pick_random, radial_random, split_random
	input  logic [127:0] s_axis_tdata,
	// func
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// sample_x, sample_y, cell_index
	output logic [39:0]  m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser
);
	import wtps_pkg::*;

	cmd_t cmd;
	res_t core_res;
	res_t out_q;
	logic out_valid_q;
	logic core_valid;
	logic core_take;

	always_comb begin
		cmd.func          = func_t'(s_axis_tuser);
		cmd.point_index   = s_axis_tdata[7:0];
		cmd.coord_x       = s_axis_tdata[23:8];
		cmd.coord_y       = s_axis_tdata[39:24];
		cmd.node_a        = s_axis_tdata[47:40];
		cmd.node_b        = s_axis_tdata[55:48];
		cmd.node_c        = s_axis_tdata[63:56];
		cmd.weight        = s_axis_tdata[79:64];
		cmd.pick_random   = s_axis_tdata[95:80];
		cmd.radial_random = s_axis_tdata[111:96];
		cmd.split_random  = s_axis_tdata[127:112];
	end

	wtps_core #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_POINTS(MAX_POINTS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(s_axis_tvalid),
		.cmd_ready(s_axis_tready),
		.cmd      (cmd),
		.res_valid(core_valid),
		.res_ready(core_take),
		.res      (core_res)
	);

	assign core_take = core_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (core_take) begin
				out_valid_q <= 1'b1;
				out_q       <= core_res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.cell_index, out_q.sample_y, out_q.sample_x};
	assign m_axis_tuser  = out_q.status;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted triangle point sampler. A built-in
// predictor keeps its own point memory and cell table. It works out the
// result of every item that is sent. Random bursts and gaps on the input and
// random stalls on the output exercise the stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import wtps_pkg::*;

	localparam int  CELL_DEPTH = 256;
	localparam int  PT_DEPTH   = 256;
	localparam longint CYCLE_LIMIT = 3000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	weighted_triangle_point_sampler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Predictor state.
	logic [31:0] pt_mem [PT_DEPTH];
	logic [23:0] cell_vtx [CELL_DEPTH];
	logic [23:0] cum_wt [CELL_DEPTH];
	int unsigned n_cells;
	logic [23:0] wt_total;
	int          written_pts[$];
	bit          pt_written [PT_DEPTH];

	res_t   pending_results[$];
	int     errors;
	int     burst_left;
	int     n_sent;
	int     n_draws_ok;
	int     n_received;
	longint cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[weighted_triangle_point_sampler_unit] ERROR");
			$finish;
		end
	end

	// Receiver stalls follow a mode that is redrawn at random.
	int rx_mode;
	always @(posedge clk) begin
		if (cycles % 300 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			2: m_axis_tready <= ((cycles % 7) < 2);
			default: m_axis_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Inputs change only at rising edges, so the level seen at the falling
	// edge is the one sampled at the next rising edge.
	always @(negedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_received++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: %h %h", $time,
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[15:0] !== want.sample_x) begin
					$display("%0t: sample_x expected %h actual %h", $time,
						want.sample_x, m_axis_tdata[15:0]);
					errors++;
				end
				if (m_axis_tdata[31:16] !== want.sample_y) begin
					$display("%0t: sample_y expected %h actual %h", $time,
						want.sample_y, m_axis_tdata[31:16]);
					errors++;
				end
				if (m_axis_tdata[39:32] !== want.cell_index) begin
					$display("%0t: cell_index expected %h actual %h", $time,
						want.cell_index, m_axis_tdata[39:32]);
					errors++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %h actual %h", $time,
						want.status, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv, rem;
		root = 0;
		bitv = 64'd1 << 30;
		rem = v;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic longint axis_of(logic [7:0] idx, int axis);
		logic [31:0] p;
		p = pt_mem[idx];
		return axis == 0 ? longint'(signed'(p[15:0])) : longint'(signed'(p[31:16]));
	endfunction

	function automatic res_t sampler_outcome(cmd_t c);
		res_t r;
		longint unsigned target, t, s, sr;
		longint a, b, cc, t1, t2;
		int unsigned i;
		int hit;
		logic [23:0] v;
		r = '0;
		r.status = ST_OK;
		case (c.func)
			FN_WRITE_POINT: begin
				pt_mem[c.point_index] = {c.coord_y, c.coord_x};
				if (!pt_written[c.point_index]) begin
					pt_written[c.point_index] = 1'b1;
					written_pts.push_back(c.point_index);
				end
			end
			FN_APPEND: begin
				if (n_cells >= CELL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					t = longint'(wt_total) + longint'(c.weight);
					if (t > 64'hFFFFFF)
						t = 64'hFFFFFF;
					cell_vtx[n_cells] = {c.node_c, c.node_b, c.node_a};
					cum_wt[n_cells] = t[23:0];
					wt_total = t[23:0];
					n_cells++;
				end
			end
			FN_SAMPLE: begin
				r.status = ST_NO_CELL;
				hit = -1;
				target = longint'(c.pick_random) * longint'(wt_total);
				if (n_cells != 0 && wt_total != 0) begin
					for (i = 0; i < n_cells; i++) begin
						if ((longint'(cum_wt[i]) << 16) > target) begin
							hit = i;
							break;
						end
					end
				end
				if (hit >= 0) begin
					v = cell_vtx[hit];
					s = int_sqrt(longint'(c.radial_random) << 16);
					sr = (s * longint'(c.split_random)) >> 16;
					for (int ax = 0; ax < 2; ax++) begin
						a = axis_of(v[7:0], ax);
						b = axis_of(v[15:8], ax);
						cc = axis_of(v[23:16], ax);
						t1 = (longint'(s) * (b - a)) >>> 16;
						t2 = (longint'(sr) * (cc - b)) >>> 16;
						if (ax == 0)
							r.sample_x = clamp16(a + t1 + t2);
						else
							r.sample_y = clamp16(a + t1 + t2);
					end
					r.cell_index = hit[7:0];
					r.status = ST_OK;
					n_draws_ok++;
				end
			end
			default: begin
				n_cells = 0;
				wt_total = '0;
			end
		endcase
		return r;
	endfunction

	task automatic send_item(cmd_t c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		pending_results.push_back(sampler_outcome(c));
		n_sent++;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.func;
		s_axis_tdata <= {c.split_random, c.radial_random, c.pick_random, c.weight,
			c.node_c, c.node_b, c.node_a, c.coord_y, c.coord_x, c.point_index};
		do
			@(negedge clk);
		while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t noise_item(func_t f);
		cmd_t c;
		c = cmd_t'({$urandom(), $urandom(), $urandom(), $urandom(), 2'b00});
		c.func = f;
		return c;
	endfunction

	function automatic logic [7:0] any_written();
		return 8'(written_pts[$urandom_range(0, written_pts.size() - 1)]);
	endfunction

	task automatic put_point(logic [7:0] idx, logic [15:0] x, logic [15:0] y);
		cmd_t c;
		c = noise_item(FN_WRITE_POINT);
		c.point_index = idx;
		c.coord_x = x;
		c.coord_y = y;
		send_item(c);
	endtask

	task automatic add_cell(logic [7:0] a, logic [7:0] b, logic [7:0] cc,
		logic [15:0] w);
		cmd_t c;
		c = noise_item(FN_APPEND);
		c.node_a = a;
		c.node_b = b;
		c.node_c = cc;
		c.weight = w;
		send_item(c);
	endtask

	task automatic draw(logic [15:0] u, logic [15:0] r1, logic [15:0] r2);
		cmd_t c;
		c = noise_item(FN_SAMPLE);
		c.pick_random = u;
		c.radial_random = r1;
		c.split_random = r2;
		send_item(c);
	endtask

	task automatic test_directed();
		draw(16'h1234, 16'hFFFF, 16'hFFFF);
		put_point(8'd0, 16'h8000, 16'h7FFF);
		put_point(8'd255, 16'h7FFF, 16'h8000);
		put_point(8'd1, 16'h0000, 16'h0000);
		put_point(8'd128, 16'h8000, 16'h8000);
		add_cell(8'd0, 8'd255, 8'd1, 16'd0);
		draw(16'h0000, 16'h8000, 16'h8000);
		add_cell(8'd0, 8'd255, 8'd128, 16'hFFFF);
		add_cell(8'd128, 8'd0, 8'd255, 16'd1);
		draw(16'h0000, 16'h0000, 16'h0000);
		draw(16'hFFFF, 16'hFFFF, 16'hFFFF);
		draw(16'hFFFE, 16'hFFFF, 16'h0000);
		draw(16'h7FFF, 16'h0001, 16'hFFFF);
		draw(16'hFFFF, 16'h4000, 16'h8000);
		send_item(noise_item(FN_CLEAR));
		draw(16'h0000, 16'h1234, 16'h5678);
		add_cell(8'd128, 8'd128, 8'd128, 16'd5);
		draw(16'hC000, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_table_full();
		send_item(noise_item(FN_CLEAR));
		for (int i = 0; i < CELL_DEPTH + 3; i++)
			add_cell(any_written(), any_written(), any_written(),
				($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom()));
		for (int i = 0; i < 10; i++)
			draw(16'($urandom()), 16'($urandom()), 16'($urandom()));
		draw(16'hFFFF, 16'hFFFF, 16'hFFFF);
		wait_results_drained();
	endtask

	task automatic test_random(int n_items);
		int pick;
		logic [15:0] w;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				put_point(8'($urandom()), 16'($urandom()), 16'($urandom()));
			end else if (pick < 50) begin
				case ($urandom_range(0, 3))
					0: w = 16'd0;
					1: w = 16'hFFFF;
					2: w = 16'($urandom_range(1, 16));
					default: w = 16'($urandom());
				endcase
				add_cell(any_written(), any_written(), any_written(), w);
			end else if (pick < 97) begin
				draw(16'($urandom()), 16'($urandom()), 16'($urandom()));
			end else begin
				send_item(noise_item(FN_CLEAR));
			end
			if (i == n_items / 2)
				wait_results_drained();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FN_WRITE_POINT;
		m_axis_tready = 1'b0;
		rx_mode = 0;
		cycles = 0;
		errors = 0;
		burst_left = 0;
		n_sent = 0;
		n_draws_ok = 0;
		n_received = 0;
		n_cells = 0;
		wt_total = '0;
		for (int i = 0; i < PT_DEPTH; i++)
			pt_written[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_results_drained();
		test_table_full();
		test_random(1400);
		wait_results_drained();
		repeat (80) @(posedge clk);

		$display("Sent %0d items, checked %0d results, %0d draws landed in a cell.",
			n_sent, n_received, n_draws_ok);
		$display("Covered empty and zero-weight tables, a full table, clears and extremes.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[weighted_triangle_point_sampler_unit] OK");
		end else begin
			$display("[weighted_triangle_point_sampler_unit] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
sv/wtps_pkg.sv
sv/wtps_mult.sv
sv/wtps_core.sv
sv/weighted_triangle_point_sampler_unit.sv
test/tb.sv
